// File: design/cps_pkg.sv
package cps_pkg;

  localparam int MAX_REGION_WIDTH_DEF = 4096;
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_ADDR_W = 4;
  localparam int THR_W = 11;

  localparam logic [1:0] REG_REGION_LEFT    = 2'd0;
  localparam logic [1:0] REG_REGION_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_DARK_THRESHOLD = 2'd2;

  localparam logic [11:0] LEFT_RESET      = 12'd0;
  localparam logic [12:0] HEIGHT_RESET    = 13'd32;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd200;

  // floor(h*15/100) = (h * 15 * ceil(2^24/100)) >> 24 for every 13-bit height.
  localparam logic [21:0] GAP_MULT   = 22'd2516595;
  localparam logic [21:0] WIDTH_MULT = 22'd1342184;
  localparam int RECIP_SHIFT = 24;
  localparam logic [THR_W-1:0] GAP_FLOOR   = 11'd4;
  localparam logic [THR_W-1:0] WIDTH_FLOOR = 11'd3;
  localparam logic [THR_W-1:0] GAP_RESET   = 11'd4;
  localparam logic [THR_W-1:0] WIDTH_RESET = 11'd3;

  localparam logic [11:0] COUNT_MAX = 12'd4095;

  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    PH_RUN,
    PH_CLOSE,
    PH_SUMMARY
  } back_phase_t;

  typedef struct packed {
    logic [11:0]      left;
    logic [THR_W-1:0] gap;
    logic [THR_W-1:0] width;
  } seg_cfg_t;

endpackage

// File: design/cps_front.sv
module cps_front #(
  parameter int MAX_REGION_WIDTH = cps_pkg::MAX_REGION_WIDTH_DEF,
  localparam int CW = $clog2(MAX_REGION_WIDTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    pixel,
  input  logic          column_end,
  input  logic          region_end,
  input  logic [7:0]    dark_threshold,
  output logic          push,
  output logic          ev_run,
  output logic          ev_region_end,
  output logic [CW-1:0] ev_begin,
  output logic [CW-1:0] ev_finish
);

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] rb_r, rb_nxt;
  logic          ink_r, ink_nxt;
  logic          run_r, run_nxt;
  logic          ink;

  always_comb begin
    col_nxt       = col_r;
    rb_nxt        = rb_r;
    ink_nxt       = ink_r;
    run_nxt       = run_r;
    ev_run        = 1'b0;
    ev_begin      = rb_r;
    ev_finish     = col_r;
    ev_region_end = 1'b0;
    ink           = ink_r | (pixel < dark_threshold);
    if (accept) begin
      ink_nxt = ink;
      if (column_end || region_end) begin
        if (col_r < CW'(MAX_REGION_WIDTH)) begin
          if (ink && !run_r) begin
            rb_nxt  = col_r;
            run_nxt = 1'b1;
          end else if (!ink && run_r) begin
            ev_run    = 1'b1;
            ev_begin  = rb_r;
            ev_finish = col_r;
            run_nxt   = 1'b0;
          end
          col_nxt = col_r + 1'b1;
        end
        ink_nxt = 1'b0;
      end
      if (region_end) begin
        if (run_nxt) begin
          ev_run    = 1'b1;
          ev_begin  = rb_nxt;
          ev_finish = col_nxt;
        end
        ev_region_end = 1'b1;
        col_nxt       = '0;
        rb_nxt        = '0;
        ink_nxt       = 1'b0;
        run_nxt       = 1'b0;
      end
    end
    push = ev_run | ev_region_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      rb_r  <= '0;
      ink_r <= 1'b0;
      run_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      rb_r  <= rb_nxt;
      ink_r <= ink_nxt;
      run_r <= run_nxt;
    end
  end

endmodule

// File: design/cps_queue.sv
module cps_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cps_pkg::QUEUE_DEPTH,
  localparam int AW = $clog2(DEPTH),
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             head_valid,
  output logic             full
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt;
  logic [AW-1:0]    rd_r, rd_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == NW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

// File: design/cps_back.sv
module cps_back #(
  parameter int MAX_REGION_WIDTH = cps_pkg::MAX_REGION_WIDTH_DEF,
  localparam int CW = $clog2(MAX_REGION_WIDTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cps_pkg::seg_cfg_t cfg,
  input  logic              head_valid,
  input  logic              head_run,
  input  logic              head_region_end,
  input  logic [CW-1:0]     head_begin,
  input  logic [CW-1:0]     head_finish,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_record_kind,
  output logic [12:0]       out_seg_begin,
  output logic [12:0]       out_seg_finish,
  output logic [11:0]       out_segment_total,
  output logic              out_final_record
);

  localparam int DW = CW + cps_pkg::THR_W;
  localparam int SW = ((CW > 12) ? CW : 12) + 1;

  cps_pkg::back_phase_t phase_r, phase_nxt;

  logic          pv_r, pv_nxt;
  logic [CW-1:0] pb_r, pb_nxt;
  logic [CW-1:0] pf_r, pf_nxt;
  logic [11:0]   cnt_r, cnt_nxt;

  logic          ov_r, ov_nxt;
  logic          kind_r, kind_nxt;
  logic [12:0]   begin_r, begin_nxt;
  logic [12:0]   finish_r, finish_nxt;
  logic [11:0]   total_r, total_nxt;
  logic          final_r, final_nxt;

  logic          free;
  logic          merge_ok;
  logic          wide_ok;
  logic          emit_seg;
  logic [SW-1:0] abs_begin, abs_finish;

  assign free      = !ov_r || !out_stall;
  assign merge_ok  = pv_r && (head_begin >= pf_r) &&
                     (DW'(head_begin - pf_r) < DW'(cfg.gap));
  assign wide_ok   = pv_r && (pf_r >= pb_r) && (DW'(pf_r - pb_r) >= DW'(cfg.width));
  assign abs_begin  = SW'(cfg.left) + SW'(pb_r);
  assign abs_finish = SW'(cfg.left) + SW'(pf_r);

  always_comb begin
    phase_nxt  = phase_r;
    pv_nxt     = pv_r;
    pb_nxt     = pb_r;
    pf_nxt     = pf_r;
    cnt_nxt    = cnt_r;
    pop        = 1'b0;
    emit_seg   = 1'b0;
    ov_nxt     = ov_r && out_stall;
    kind_nxt   = kind_r;
    begin_nxt  = begin_r;
    finish_nxt = finish_r;
    total_nxt  = total_r;
    final_nxt  = final_r;

    case (phase_r)
      cps_pkg::PH_RUN: begin
        if (head_valid) begin
          if (!head_run) begin
            phase_nxt = cps_pkg::PH_CLOSE;
          end else if (merge_ok) begin
            pf_nxt = head_finish;
            if (head_region_end) begin
              phase_nxt = cps_pkg::PH_CLOSE;
            end else begin
              pop = 1'b1;
            end
          end else if (!wide_ok || free) begin
            emit_seg = wide_ok;
            pv_nxt   = 1'b1;
            pb_nxt   = head_begin;
            pf_nxt   = head_finish;
            if (head_region_end) begin
              phase_nxt = cps_pkg::PH_CLOSE;
            end else begin
              pop = 1'b1;
            end
          end
        end
      end
      cps_pkg::PH_CLOSE: begin
        if (!wide_ok || free) begin
          emit_seg  = wide_ok;
          pv_nxt    = 1'b0;
          phase_nxt = cps_pkg::PH_SUMMARY;
        end
      end
      cps_pkg::PH_SUMMARY: begin
        if (free) begin
          ov_nxt     = 1'b1;
          kind_nxt   = cps_pkg::KIND_SUMMARY;
          begin_nxt  = '0;
          finish_nxt = '0;
          total_nxt  = cnt_r;
          final_nxt  = 1'b1;
          pv_nxt     = 1'b0;
          pb_nxt     = '0;
          pf_nxt     = '0;
          cnt_nxt    = '0;
          pop        = 1'b1;
          phase_nxt  = cps_pkg::PH_RUN;
        end
      end
      default: begin
        phase_nxt = cps_pkg::PH_RUN;
      end
    endcase

    if (emit_seg) begin
      ov_nxt     = 1'b1;
      kind_nxt   = cps_pkg::KIND_SEGMENT;
      begin_nxt  = 13'(abs_begin);
      finish_nxt = 13'(abs_finish);
      total_nxt  = '0;
      final_nxt  = 1'b0;
      if (cnt_r != cps_pkg::COUNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cps_pkg::PH_RUN;
      pv_r    <= 1'b0;
      pb_r    <= '0;
      pf_r    <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pv_r    <= pv_nxt;
      pb_r    <= pb_nxt;
      pf_r    <= pf_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    begin_r  <= begin_nxt;
    finish_r <= finish_nxt;
    total_r  <= total_nxt;
    final_r  <= final_nxt;
  end

  assign out_valid         = ov_r;
  assign out_record_kind   = kind_r;
  assign out_seg_begin     = begin_r;
  assign out_seg_finish    = finish_r;
  assign out_segment_total = total_r;
  assign out_final_record  = final_r;

endmodule

// File: design/column_projection_segmenter.sv
// Column projection segmenter. One pixel transfer is accepted every clock cycle, column by
// column; a column that holds any pixel darker than dark_threshold counts as ink. The front
// end tracks ink runs and hands finished runs and region ends through a four-entry queue to
// the back end, which merges runs, filters narrow ones and drives a registered output. The
// back end retires finished runs one by one and takes a region end through the last run,
// the pending segment and the summary in turn. The input therefore stalls when the queue
// fills, either behind a stalled consumer or when region ends arrive faster than the back
// end closes them for long enough, as with a stream of regions that are only one or two
// pixels each. Write the registers only while no region is in flight; the gap and width
// thresholds are derived from region_height as it is written.
module column_projection_segmenter #(
  parameter int MAX_REGION_WIDTH = cps_pkg::MAX_REGION_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_pixel,
  input  logic                           in_column_end,
  input  logic                           in_region_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_record_kind,
  output logic [12:0]                    out_seg_begin,
  output logic [12:0]                    out_seg_finish,
  output logic [11:0]                    out_segment_total,
  output logic                           out_final_record,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [cps_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  localparam int CW = $clog2(MAX_REGION_WIDTH + 1);
  localparam int EW = 2 + 2 * CW;

  logic [11:0]               left_r;
  logic [12:0]               height_r;
  logic [7:0]                thr_r;
  logic [cps_pkg::THR_W-1:0] gap_r, gap_nxt;
  logic [cps_pkg::THR_W-1:0] wid_r, wid_nxt;
  logic [34:0]               gap_prod, wid_prod;
  logic [cps_pkg::THR_W-1:0] gap_raw, wid_raw;
  logic                      cfg_wr;
  logic [1:0]                cfg_idx;
  cps_pkg::seg_cfg_t         seg_cfg;

  logic          in_accept;
  logic          q_push, q_pop, q_full, q_head_valid;
  logic          ev_run, ev_region_end;
  logic [CW-1:0] ev_begin, ev_finish;
  logic [EW-1:0] q_in, q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  assign gap_prod = 35'(cfg_pwdata[12:0]) * 35'(cps_pkg::GAP_MULT);
  assign wid_prod = 35'(cfg_pwdata[12:0]) * 35'(cps_pkg::WIDTH_MULT);
  assign gap_raw  = gap_prod[cps_pkg::RECIP_SHIFT +: cps_pkg::THR_W];
  assign wid_raw  = wid_prod[cps_pkg::RECIP_SHIFT +: cps_pkg::THR_W];
  assign gap_nxt  = (gap_raw > cps_pkg::GAP_FLOOR) ? gap_raw : cps_pkg::GAP_FLOOR;
  assign wid_nxt  = (wid_raw > cps_pkg::WIDTH_FLOOR) ? wid_raw : cps_pkg::WIDTH_FLOOR;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= cps_pkg::LEFT_RESET;
      height_r <= cps_pkg::HEIGHT_RESET;
      thr_r    <= cps_pkg::THRESHOLD_RESET;
      gap_r    <= cps_pkg::GAP_RESET;
      wid_r    <= cps_pkg::WIDTH_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cps_pkg::REG_REGION_LEFT: begin
          left_r <= cfg_pwdata[11:0];
        end
        cps_pkg::REG_REGION_HEIGHT: begin
          height_r <= cfg_pwdata[12:0];
          gap_r    <= gap_nxt;
          wid_r    <= wid_nxt;
        end
        cps_pkg::REG_DARK_THRESHOLD: begin
          thr_r <= cfg_pwdata[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      cps_pkg::REG_REGION_LEFT:    cfg_prdata = 32'(left_r);
      cps_pkg::REG_REGION_HEIGHT:  cfg_prdata = 32'(height_r);
      cps_pkg::REG_DARK_THRESHOLD: cfg_prdata = 32'(thr_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  assign seg_cfg.left  = left_r;
  assign seg_cfg.gap   = gap_r;
  assign seg_cfg.width = wid_r;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  cps_front #(
    .MAX_REGION_WIDTH(MAX_REGION_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .pixel         (in_pixel),
    .column_end    (in_column_end),
    .region_end    (in_region_end),
    .dark_threshold(thr_r),
    .push          (q_push),
    .ev_run        (ev_run),
    .ev_region_end (ev_region_end),
    .ev_begin      (ev_begin),
    .ev_finish     (ev_finish)
  );

  assign q_in = {ev_run, ev_region_end, ev_begin, ev_finish};

  cps_queue #(
    .WIDTH(EW),
    .DEPTH(cps_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .head_valid(q_head_valid),
    .full      (q_full)
  );

  cps_back #(
    .MAX_REGION_WIDTH(MAX_REGION_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (seg_cfg),
    .head_valid       (q_head_valid),
    .head_run         (q_head[EW-1]),
    .head_region_end  (q_head[EW-2]),
    .head_begin       (q_head[2*CW-1:CW]),
    .head_finish      (q_head[CW-1:0]),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_record_kind  (out_record_kind),
    .out_seg_begin    (out_seg_begin),
    .out_seg_finish   (out_seg_finish),
    .out_segment_total(out_segment_total),
    .out_final_record (out_final_record)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid)
    else $error("queue read while empty");

  a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_record_kind == cps_pkg::KIND_SUMMARY)) |->
      (out_final_record && (out_seg_begin == 13'd0) && (out_seg_finish == 13'd0)))
    else $error("malformed summary record");

endmodule
